### src/barg_pkg.sv
package barg_pkg;

  // default sizes
  localparam int BAND_COUNT_DEF  = 64;
  localparam int MAX_SAMPLES_DEF = 4096;

  // field widths
  localparam int BAND_W  = 6;
  localparam int GAIN_W  = 17;
  localparam int COUNT_W = 13;
  localparam int COEFF_W = 24;
  localparam int STATE_W = 25;
  localparam int FRAC_W  = 24;

  // fixed-point constants
  localparam logic [STATE_W-1:0] GAIN_UNITY   = STATE_W'(32'd16777216);
  localparam logic [GAIN_W-1:0]  TARGET_UNITY = GAIN_W'(32'd65536);
  localparam logic [STATE_W:0]   OUT_ROUND    = (STATE_W+1)'(32'd128);

  // configuration registers
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
  localparam logic [COEFF_W-1:0] ATTACK_RESET  = 24'd345830;
  localparam logic [COEFF_W-1:0] RELEASE_RESET = 24'd3495;

  // request item
  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [GAIN_W-1:0]  target_gain;
    logic [COUNT_W-1:0] sample_count;
  } barg_in_t;

  // result item
  typedef struct packed {
    logic [BAND_W-1:0] band_out;
    logic [GAIN_W-1:0] smoothed_gain;
  } barg_out_t;

  // sequencer states
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_DONE  = 6'b100000
  } barg_state_t;

endpackage

### src/barg_gain_mem.sv
module barg_gain_mem #(
  parameter int DEPTH  = barg_pkg::BAND_COUNT_DEF,
  parameter int ADDR_W = 6
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [barg_pkg::STATE_W-1:0] wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [barg_pkg::STATE_W-1:0] rdata
);

  logic [barg_pkg::STATE_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/barg_step_unit.sv
module barg_step_unit (
  input  logic                         clk,
  input  logic                         mul_en,
  input  logic [barg_pkg::STATE_W-1:0] value,
  input  logic [barg_pkg::STATE_W-1:0] target,
  input  logic [barg_pkg::COEFF_W-1:0] attack_coeff,
  input  logic [barg_pkg::COEFF_W-1:0] release_coeff,
  output logic [barg_pkg::STATE_W-1:0] next_value
);

  localparam int DIFF_W  = barg_pkg::STATE_W + 1;
  localparam int PROD_W  = DIFF_W + barg_pkg::COEFF_W + 1;
  localparam int DELTA_W = PROD_W - barg_pkg::FRAC_W;
  localparam int SUM_W   = barg_pkg::STATE_W + 3;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (barg_pkg::FRAC_W - 1));

  logic signed [DIFF_W-1:0]      diff;
  logic [barg_pkg::COEFF_W-1:0]  coeff;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      rounded;
  logic signed [DELTA_W-1:0]     delta;
  logic signed [SUM_W-1:0]       sum;

  // error toward target, attack when the gain falls
  always_comb begin
    diff  = $signed({1'b0, target}) - $signed({1'b0, value});
    coeff = diff[DIFF_W-1] ? attack_coeff : release_coeff;
  end

  // multiply phase
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(diff) * PROD_W'($signed({1'b0, coeff}));
    end
  end

  // add phase: round to nearest, accumulate, clamp to 0..unity
  always_comb begin
    rounded = prod + ROUND_HALF;
    delta   = rounded[PROD_W-1:barg_pkg::FRAC_W];
    sum     = $signed({3'b000, value}) + SUM_W'(delta);
    if (sum[SUM_W-1]) begin
      next_value = '0;
    end else if (sum > $signed({3'b000, barg_pkg::GAIN_UNITY})) begin
      next_value = barg_pkg::GAIN_UNITY;
    end else begin
      next_value = sum[barg_pkg::STATE_W-1:0];
    end
  end

endmodule

### src/banked_attack_release_gain_smoother.sv
// a request runs LOAD, N steps of MUL then ADD, and DONE, which registers the result
// once the output is free; N = sample count after saturation. Each step is a multiply
// state plus an add state through the one shared step unit, and req_ready stays low
// until the result is stored. Reset: coefficients return to their defaults and a clear
// sweep writes unity to every band gain, during which no request is accepted
module banked_attack_release_gain_smoother #(
  parameter int BAND_COUNT  = barg_pkg::BAND_COUNT_DEF,
  parameter int MAX_SAMPLES = barg_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  barg_pkg::barg_in_t             req_item,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output barg_pkg::barg_out_t            rsp_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [barg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [barg_pkg::COEFF_W-1:0]   cfg_data
);

  localparam int SLOT_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int BAND_SPAN = 1 << barg_pkg::BAND_W;

  barg_pkg::barg_state_t state;
  barg_pkg::barg_state_t state_next;

  logic [SLOT_W-1:0]                clr_idx;
  logic [barg_pkg::BAND_W-1:0]      band_q;
  logic [SLOT_W-1:0]                slot_q;
  logic [barg_pkg::STATE_W-1:0]     target_q;
  logic [barg_pkg::COUNT_W-1:0]     steps_left;
  logic [barg_pkg::STATE_W-1:0]     value;
  logic [barg_pkg::COEFF_W-1:0]     attack_coeff;
  logic [barg_pkg::COEFF_W-1:0]     release_coeff;

  logic                             req_accept;
  logic                             out_free;
  logic [SLOT_W-1:0]                slot_in;
  logic [barg_pkg::GAIN_W-1:0]      target_sat;
  logic [barg_pkg::COUNT_W-1:0]     count_sat;
  logic                             mem_we;
  logic [SLOT_W-1:0]                mem_waddr;
  logic [barg_pkg::STATE_W-1:0]     mem_wdata;
  logic [barg_pkg::STATE_W-1:0]     mem_rdata;
  logic [barg_pkg::STATE_W-1:0]     step_value;
  logic [barg_pkg::STATE_W:0]       out_rounded;

  assign req_ready  = (state == barg_pkg::ST_IDLE);
  assign req_accept = req_valid && req_ready;
  assign out_free   = !rsp_valid || rsp_ready;
  assign cfg_ready  = 1'b1;

  // band index wraps onto the bank
  always_comb begin
    slot_in = '0;
    for (int i = 0; i < BAND_SPAN; i++) begin
      if (req_item.band == barg_pkg::BAND_W'(i)) begin
        slot_in = SLOT_W'(i % BAND_COUNT);
      end
    end
  end

  // saturate target and count
  always_comb begin
    target_sat = (req_item.target_gain > barg_pkg::TARGET_UNITY) ?
                 barg_pkg::TARGET_UNITY : req_item.target_gain;
    count_sat  = (32'(req_item.sample_count) > MAX_SAMPLES) ?
                 barg_pkg::COUNT_W'(MAX_SAMPLES) : req_item.sample_count;
  end

  // memory write: clear sweep or write-back of the finished gain
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = value;
    case (state)
      barg_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = barg_pkg::GAIN_UNITY;
      end
      barg_pkg::ST_DONE: begin
        mem_we = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  barg_gain_mem #(
    .DEPTH  (BAND_COUNT),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (req_accept),
    .raddr (slot_in),
    .rdata (mem_rdata)
  );

  barg_step_unit u_step (
    .clk           (clk),
    .mul_en        (state == barg_pkg::ST_MUL),
    .value         (value),
    .target        (target_q),
    .attack_coeff  (attack_coeff),
    .release_coeff (release_coeff),
    .next_value    (step_value)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      barg_pkg::ST_CLEAR: begin
        if (clr_idx == SLOT_W'(BAND_COUNT - 1)) begin
          state_next = barg_pkg::ST_IDLE;
        end
      end
      barg_pkg::ST_IDLE: begin
        if (req_accept) begin
          state_next = barg_pkg::ST_LOAD;
        end
      end
      barg_pkg::ST_LOAD: begin
        state_next = (steps_left == '0) ? barg_pkg::ST_DONE : barg_pkg::ST_MUL;
      end
      barg_pkg::ST_MUL: begin
        state_next = barg_pkg::ST_ADD;
      end
      barg_pkg::ST_ADD: begin
        state_next = (steps_left == barg_pkg::COUNT_W'(1)) ?
                     barg_pkg::ST_DONE : barg_pkg::ST_MUL;
      end
      barg_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = barg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = barg_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= barg_pkg::ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == barg_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + SLOT_W'(1);
      end
    end
  end

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff  <= barg_pkg::ATTACK_RESET;
      release_coeff <= barg_pkg::RELEASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        barg_pkg::CFG_ATTACK:  attack_coeff  <= cfg_data;
        barg_pkg::CFG_RELEASE: release_coeff <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // item registers and working gain
  always_ff @(posedge clk) begin
    if (req_accept) begin
      band_q     <= req_item.band;
      slot_q     <= slot_in;
      target_q   <= {target_sat, 8'b0};
      steps_left <= count_sat;
    end
    if (state == barg_pkg::ST_LOAD) begin
      value <= mem_rdata;
    end
    if (state == barg_pkg::ST_ADD) begin
      value      <= step_value;
      steps_left <= steps_left - barg_pkg::COUNT_W'(1);
    end
  end

  // result register
  assign out_rounded = {1'b0, value} + barg_pkg::OUT_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == barg_pkg::ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == barg_pkg::ST_DONE && out_free) begin
      rsp_item.band_out      <= band_q;
      rsp_item.smoothed_gain <= out_rounded[barg_pkg::STATE_W-1:8];
    end
  end

  // a step never leaves the gain above unity
  assert property (@(posedge clk) disable iff (rst)
    (state == barg_pkg::ST_ADD) |=> (value <= barg_pkg::GAIN_UNITY))
    else $error("gain above unity after step");

  // steps only run while work is left
  assert property (@(posedge clk) disable iff (rst)
    (state == barg_pkg::ST_MUL || state == barg_pkg::ST_ADD) |-> (steps_left != '0))
    else $error("step issued with no steps left");

  // no second item taken while one is in work
  assert property (@(posedge clk) disable iff (rst)
    req_accept |=> !req_ready)
    else $error("request accepted while busy");

endmodule
